// ----- design/dedt_pkg.sv -----
package dedt_pkg;

    // sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_NORM,
        ST_LEVEL,
        ST_SETUP,
        ST_DIV,
        ST_MUL,
        ST_APPLY,
        ST_DETECT,
        ST_DONE
    } state_t;

    // envelope served by the shared unit
    typedef enum logic [1:0] {
        TRK_FAST,
        TRK_SLOW,
        TRK_OUT
    } track_t;

    // configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_FAST_ATTACK = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FAST_DECAY  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SLOW_ATTACK = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SLOW_DECAY  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_OUT_ATTACK  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_OUT_DECAY   = 3'd6;

    // widths
    localparam int TAU_W   = 24;
    localparam int LEVEL_W = 16;
    localparam int DT_W    = 20;
    localparam int DB_W    = 16;

    // register reset values
    localparam logic [TAU_W-1:0]   RST_FAST_ATTACK = 24'd50000;
    localparam logic [TAU_W-1:0]   RST_FAST_DECAY  = 24'd50000;
    localparam logic [TAU_W-1:0]   RST_SLOW_ATTACK = 24'd300000;
    localparam logic [TAU_W-1:0]   RST_SLOW_DECAY  = 24'd300000;
    localparam logic [LEVEL_W-1:0] RST_THRESHOLD   = 16'd3277;
    localparam logic [TAU_W-1:0]   RST_OUT_ATTACK  = 24'd10000;
    localparam logic [TAU_W-1:0]   RST_OUT_DECAY   = 24'd300000;

    // arithmetic constants
    localparam logic [LEVEL_W-1:0] ONE_Q15   = 16'd32768;
    localparam logic [16:0]        SPAN_Q8   = 17'sd15360;
    // floor(x / 15) = (x * RECIP_15) >> 19 for x below 2^15
    localparam logic [15:0]        RECIP_15  = 16'd34953;
    localparam int                 ALPHA_BITS = 15;

endpackage

// ----- design/dual_envelope_transient_detector.sv -----
// Dual envelope transient detector.
//
// Input channel s_*: one word per analysis frame (level in dB Q8.8, elapsed time in
// microseconds, analyzer valid flag). Result channel m_*: one word per input word with
// the transient level (Q1.15) and the detect flag. Configuration channel cfg_*: index
// and data, always ready. Registers must be written only while no frame is in flight;
// the block itself does not enforce it.
//
// One shared restoring divider (one quotient bit per cycle) and one shared 17x16
// multiplier serve the fast, slow and output envelopes in turn; the multiplier also
// normalizes the level. Each envelope passes through setup, the divider, a multiply and
// an apply step, but skips the divider when its time constant is zero or already elapsed.
// s_ready is high only in the idle state, so the next frame is not taken before the
// previous result word is registered. The result sits in an output register, so a stalled
// receiver does not stop the next frame from being worked on; only its delivery waits for
// m_ready. Reset (aresetn low, synchronous) restores the register defaults and clears all
// envelopes to zero.
module dual_envelope_transient_detector (
    input  logic                                aclk,
    input  logic                                aresetn,
    // input words
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic signed [dedt_pkg::DB_W-1:0]    s_level_db,
    input  logic        [dedt_pkg::DT_W-1:0]    s_elapsed_us,
    input  logic                                s_analyzer_valid,
    // result words
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic        [dedt_pkg::LEVEL_W-1:0] m_transient_level,
    output logic                                m_detecting,
    // configuration writes
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic        [dedt_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic        [dedt_pkg::TAU_W-1:0]   cfg_data
);

    localparam int TW = dedt_pkg::TAU_W;
    localparam int LW = dedt_pkg::LEVEL_W;

    dedt_pkg::state_t state_reg, state_next;
    dedt_pkg::track_t trk_reg, trk_next;

    // configuration registers
    logic [TW-1:0] fast_attack_reg, fast_decay_reg, slow_attack_reg, slow_decay_reg;
    logic [TW-1:0] out_attack_reg, out_decay_reg;
    logic [LW-1:0] threshold_reg;

    // frame registers
    logic signed [dedt_pkg::DB_W-1:0] db_reg;
    logic [dedt_pkg::DT_W-1:0]        dt_reg;

    // state and working registers
    logic [LW-1:0] fast_env_reg, fast_env_next;
    logic [LW-1:0] slow_env_reg, slow_env_next;
    logic [LW-1:0] tran_env_reg, tran_env_next;
    logic [LW-1:0] level_reg, level_next;
    logic          det_reg, det_next;
    logic [LW-1:0] alpha_reg, alpha_next;
    logic [TW-1:0] rem_reg, rem_next;
    logic [3:0]    cnt_reg, cnt_next;
    logic [32:0]   prod_reg;

    // output register
    logic          m_valid_reg, m_valid_next;
    logic [LW-1:0] m_level_reg, m_level_next;
    logic          m_det_reg, m_det_next;

    // combinational datapath signals
    logic signed [16:0] s_sum;
    logic        [14:0] norm_x;
    logic        [LW-1:0] cur_env, cur_target, step_val, diff_val, env_new;
    logic        [TW-1:0] cur_tau;
    logic                 tau_full;
    logic        [TW:0]   rem_dbl;
    logic                 rem_ge;
    logic        [16:0]   mul_a;
    logic        [15:0]   mul_b;
    logic        [LW-1:0] env_gap;
    logic                 out_take;

    assign s_ready   = (state_reg == dedt_pkg::ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_valid           = m_valid_reg;
    assign m_transient_level = m_level_reg;
    assign m_detecting       = m_det_reg;

    assign out_take = !m_valid_reg || m_ready;

    // level normalization terms
    assign s_sum  = 17'(db_reg) + dedt_pkg::SPAN_Q8;
    assign norm_x = {s_sum[13:0], 1'b0};

    // envelope, target and time constant for the current track
    always_comb begin
        case (trk_reg)
            dedt_pkg::TRK_FAST: begin
                cur_env    = fast_env_reg;
                cur_target = level_reg;
                cur_tau    = (level_reg > fast_env_reg) ? fast_attack_reg : fast_decay_reg;
            end
            dedt_pkg::TRK_SLOW: begin
                cur_env    = slow_env_reg;
                cur_target = level_reg;
                cur_tau    = (level_reg > slow_env_reg) ? slow_attack_reg : slow_decay_reg;
            end
            default: begin
                cur_env    = tran_env_reg;
                cur_target = det_reg ? dedt_pkg::ONE_Q15 : '0;
                cur_tau    = det_reg ? out_attack_reg : out_decay_reg;
            end
        endcase
    end

    assign tau_full = (cur_tau == '0) || ({4'b0, dt_reg} >= cur_tau);
    assign diff_val = (cur_target >= cur_env) ? (cur_target - cur_env)
                                              : (cur_env - cur_target);
    assign step_val = prod_reg[30:15];
    assign env_new  = (cur_target >= cur_env) ? (cur_env + step_val)
                                              : (cur_env - step_val);

    // divider step: one quotient bit per cycle
    assign rem_dbl = {rem_reg, 1'b0};
    assign rem_ge  = rem_dbl >= {1'b0, cur_tau};

    // shared multiplier operands
    always_comb begin
        if (state_reg == dedt_pkg::ST_NORM) begin
            mul_a = {2'b0, norm_x};
            mul_b = dedt_pkg::RECIP_15;
        end else begin
            mul_a = {1'b0, diff_val};
            mul_b = alpha_reg;
        end
    end

    assign env_gap = fast_env_reg - slow_env_reg;

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            dedt_pkg::ST_IDLE: begin
                if (s_valid) begin
                    state_next = s_analyzer_valid ? dedt_pkg::ST_NORM : dedt_pkg::ST_SETUP;
                end
            end
            dedt_pkg::ST_NORM:  state_next = dedt_pkg::ST_LEVEL;
            dedt_pkg::ST_LEVEL: state_next = dedt_pkg::ST_SETUP;
            dedt_pkg::ST_SETUP: begin
                state_next = tau_full ? dedt_pkg::ST_MUL : dedt_pkg::ST_DIV;
            end
            dedt_pkg::ST_DIV: begin
                if (cnt_reg == 4'(dedt_pkg::ALPHA_BITS - 1)) begin
                    state_next = dedt_pkg::ST_MUL;
                end
            end
            dedt_pkg::ST_MUL: state_next = dedt_pkg::ST_APPLY;
            dedt_pkg::ST_APPLY: begin
                case (trk_reg)
                    dedt_pkg::TRK_FAST: state_next = dedt_pkg::ST_SETUP;
                    dedt_pkg::TRK_SLOW: state_next = dedt_pkg::ST_DETECT;
                    default:            state_next = dedt_pkg::ST_DONE;
                endcase
            end
            dedt_pkg::ST_DETECT: state_next = dedt_pkg::ST_SETUP;
            dedt_pkg::ST_DONE: begin
                if (out_take) begin
                    state_next = dedt_pkg::ST_IDLE;
                end
            end
            default: state_next = dedt_pkg::ST_IDLE;
        endcase
    end

    // datapath updates
    always_comb begin
        trk_next      = trk_reg;
        fast_env_next = fast_env_reg;
        slow_env_next = slow_env_reg;
        tran_env_next = tran_env_reg;
        level_next    = level_reg;
        det_next      = det_reg;
        alpha_next    = alpha_reg;
        rem_next      = rem_reg;
        cnt_next      = cnt_reg;
        m_valid_next  = m_valid_reg;
        m_level_next  = m_level_reg;
        m_det_next    = m_det_reg;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            dedt_pkg::ST_IDLE: begin
                det_next = 1'b0;
                trk_next = s_analyzer_valid ? dedt_pkg::TRK_FAST : dedt_pkg::TRK_OUT;
            end
            dedt_pkg::ST_LEVEL: begin
                // clamp ends, else 2s + floor(2s / 15)
                if (s_sum <= 17'sd0) begin
                    level_next = '0;
                end else if (s_sum >= dedt_pkg::SPAN_Q8) begin
                    level_next = dedt_pkg::ONE_Q15;
                end else begin
                    level_next = {1'b0, norm_x} + {5'b0, prod_reg[29:19]};
                end
            end
            dedt_pkg::ST_SETUP: begin
                cnt_next = '0;
                if (tau_full) begin
                    alpha_next = dedt_pkg::ONE_Q15;
                end else begin
                    alpha_next = '0;
                    rem_next   = {4'b0, dt_reg};
                end
            end
            dedt_pkg::ST_DIV: begin
                alpha_next = {alpha_reg[LW-2:0], rem_ge};
                rem_next   = rem_ge ? TW'(rem_dbl - {1'b0, cur_tau}) : rem_dbl[TW-1:0];
                cnt_next   = cnt_reg + 4'd1;
            end
            dedt_pkg::ST_APPLY: begin
                case (trk_reg)
                    dedt_pkg::TRK_FAST: begin
                        fast_env_next = env_new;
                        trk_next      = dedt_pkg::TRK_SLOW;
                    end
                    dedt_pkg::TRK_SLOW: slow_env_next = env_new;
                    default:            tran_env_next = env_new;
                endcase
            end
            dedt_pkg::ST_DETECT: begin
                det_next = (fast_env_reg > slow_env_reg) && (env_gap > threshold_reg);
                trk_next = dedt_pkg::TRK_OUT;
            end
            dedt_pkg::ST_DONE: begin
                if (out_take) begin
                    m_valid_next = 1'b1;
                    m_level_next = tran_env_reg;
                    m_det_next   = det_reg;
                end
            end
            default: begin
            end
        endcase
    end

    // registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= dedt_pkg::ST_IDLE;
            trk_reg         <= dedt_pkg::TRK_FAST;
            fast_attack_reg <= dedt_pkg::RST_FAST_ATTACK;
            fast_decay_reg  <= dedt_pkg::RST_FAST_DECAY;
            slow_attack_reg <= dedt_pkg::RST_SLOW_ATTACK;
            slow_decay_reg  <= dedt_pkg::RST_SLOW_DECAY;
            threshold_reg   <= dedt_pkg::RST_THRESHOLD;
            out_attack_reg  <= dedt_pkg::RST_OUT_ATTACK;
            out_decay_reg   <= dedt_pkg::RST_OUT_DECAY;
            fast_env_reg    <= '0;
            slow_env_reg    <= '0;
            tran_env_reg    <= '0;
            det_reg         <= 1'b0;
            cnt_reg         <= '0;
            m_valid_reg     <= 1'b0;
        end else begin
            state_reg    <= state_next;
            trk_reg      <= trk_next;
            fast_env_reg <= fast_env_next;
            slow_env_reg <= slow_env_next;
            tran_env_reg <= tran_env_next;
            det_reg      <= det_next;
            cnt_reg      <= cnt_next;
            m_valid_reg  <= m_valid_next;
            // configuration word
            if (cfg_valid) begin
                case (cfg_index)
                    dedt_pkg::REG_FAST_ATTACK: fast_attack_reg <= cfg_data;
                    dedt_pkg::REG_FAST_DECAY:  fast_decay_reg  <= cfg_data;
                    dedt_pkg::REG_SLOW_ATTACK: slow_attack_reg <= cfg_data;
                    dedt_pkg::REG_SLOW_DECAY:  slow_decay_reg  <= cfg_data;
                    dedt_pkg::REG_THRESHOLD:   threshold_reg   <= cfg_data[LW-1:0];
                    dedt_pkg::REG_OUT_ATTACK:  out_attack_reg  <= cfg_data;
                    dedt_pkg::REG_OUT_DECAY:   out_decay_reg   <= cfg_data;
                    default: begin
                    end
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            db_reg <= s_level_db;
            dt_reg <= s_elapsed_us;
        end
        level_reg   <= level_next;
        alpha_reg   <= alpha_next;
        rem_reg     <= rem_next;
        prod_reg    <= mul_a * mul_b;
        m_level_reg <= m_level_next;
        m_det_reg   <= m_det_next;
    end

endmodule
